// ===== rtl/qalu_pkg.sv =====
`default_nettype none

package qalu_pkg;

	typedef enum logic [2:0] {
		ACT_ADD   = 3'd0,
		ACT_SUB   = 3'd1,
		ACT_MUL   = 3'd2,
		ACT_SCALE = 3'd3,
		ACT_CONJ  = 3'd4,
		ACT_NEG   = 3'd5,
		ACT_DOT   = 3'd6,
		ACT_MAT   = 3'd7
	} action_t;

	typedef logic signed [15:0] fix16_t;
	typedef logic signed [31:0] prod_t;
	typedef logic signed [35:0] fix36_t;

	// index 0 is w, then x, y, z
	typedef fix16_t [3:0] quat_t;
	typedef prod_t [3:0][3:0] prods_t;
	typedef logic [1:0] row_t;

	localparam row_t ROW_FIRST = 2'd0;
	localparam row_t ROW_MID = 2'd1;
	localparam row_t ROW_LAST = 2'd2;

	localparam int Q14_SHIFT = 14;
	localparam fix36_t ONE_Q28 = 36'sd268435456;

	typedef struct packed {
		action_t action;
		fix16_t  a_w;
		fix16_t  a_x;
		fix16_t  a_y;
		fix16_t  a_z;
		fix16_t  b_w;
		fix16_t  b_x;
		fix16_t  b_y;
		fix16_t  b_z;
		fix16_t  scalar;
	} req_t;

	typedef struct packed {
		fix36_t out_0;
		fix36_t out_1;
		fix36_t out_2;
		fix36_t out_3;
		logic   last;
	} rsp_t;

	typedef struct packed {
		action_t action;
		quat_t   a;
		quat_t   b;
		prods_t  p;
	} stage_t;

	function automatic fix36_t ext32(input prod_t v);
		return fix36_t'($signed(v));
	endfunction

	function automatic fix36_t ext16(input fix16_t v);
		return fix36_t'($signed(v));
	endfunction

endpackage

`default_nettype wire

// ===== rtl/quaternion_alu.sv =====
// quaternion_alu: fixed-point quaternion arithmetic, Q1.14 in, Q7.28 out
//
// request channel: req_valid / req_ready with payload req (action, a, b, scalar)
// response channel: rsp_valid / rsp_ready with payload rsp (out_0..out_3, last)
//
// pipeline: input register, sixteen 16x16 multipliers into a product
// register, then add/select logic into the response register. an accepted
// request passes through the input, product and response registers in turn.
// while the receiver keeps up, one request per cycle is taken for every
// action but the matrix conversion, which produces three rows from the
// product register and holds the pipeline behind it until its last row
// (last set on row 2 only). other actions give one response with last set.
//
// when the receiver stalls, the response register holds its value and the
// stall propagates back stage by stage; req_ready drops once every stage is
// full. arst_n clears all valid flags and the row counter; no response is
// pending after reset.
`default_nettype none

module quaternion_alu (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	output logic               req_ready,
	input  wire qalu_pkg::req_t req,
	output logic               rsp_valid,
	input  wire                rsp_ready,
	output qalu_pkg::rsp_t     rsp
);

	qalu_pkg::req_t   req_s1;
	logic             valid_s1;
	qalu_pkg::stage_t st_s2;
	logic             valid_s2;
	qalu_pkg::row_t   row_q;
	qalu_pkg::rsp_t   rsp_q;
	logic             rsp_valid_q;

	qalu_pkg::quat_t  a_s1, b_s1;
	qalu_pkg::prods_t prods;
	qalu_pkg::rsp_t   rsp_next;

	logic out_load, s2_done_row, s2_free;

	assign a_s1 = {req_s1.a_z, req_s1.a_y, req_s1.a_x, req_s1.a_w};
	assign b_s1 = {req_s1.b_z, req_s1.b_y, req_s1.b_x, req_s1.b_w};

	qalu_mult u_mult (
		.action (req_s1.action),
		.a      (a_s1),
		.b      (b_s1),
		.scalar (req_s1.scalar),
		.p      (prods)
	);

	qalu_combine u_combine (
		.st  (st_s2),
		.row (row_q),
		.rsp (rsp_next)
	);

	assign out_load = valid_s2 && (!rsp_valid_q || rsp_ready);
	assign s2_done_row = rsp_next.last;
	assign s2_free = !valid_s2 || (out_load && s2_done_row);
	assign req_ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			st_s2.action <= req_s1.action;
			st_s2.a <= a_s1;
			st_s2.b <= b_s1;
			st_s2.p <= prods;
		end
	end

	// matrix row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= qalu_pkg::ROW_FIRST;
		end else if (out_load) begin
			if (s2_done_row) begin
				row_q <= qalu_pkg::ROW_FIRST;
			end else begin
				row_q <= row_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q != 2'd3)
		else $error("row counter out of range");

	a_row_matrix: assert property (@(posedge clk) disable iff (!arst_n)
		row_q != qalu_pkg::ROW_FIRST |-> valid_s2 && st_s2.action == qalu_pkg::ACT_MAT)
		else $error("row counter running without a matrix request");

	a_rows_pending: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_q.last |-> valid_s2 && st_s2.action == qalu_pkg::ACT_MAT)
		else $error("matrix rows missing after a non-final row");

	a_accept_fill: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> valid_s1)
		else $error("accepted request lost from input stage");

endmodule

`default_nettype wire

// ===== rtl/qalu_mult.sv =====
`default_nettype none

module qalu_mult (
	input  wire qalu_pkg::action_t action,
	input  wire qalu_pkg::quat_t   a,
	input  wire qalu_pkg::quat_t   b,
	input  wire qalu_pkg::fix16_t  scalar,
	output qalu_pkg::prods_t       p
);

	qalu_pkg::quat_t op;

	// second operand: b for product, dot and all other actions, a for matrix, scalar for scaling
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			priority if (action == qalu_pkg::ACT_MAT) begin
				op[j] = a[j];
			end else if (action == qalu_pkg::ACT_SCALE) begin
				op[j] = scalar;
			end else begin
				op[j] = b[j];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				p[i][j] = qalu_pkg::prod_t'(a[i]) * qalu_pkg::prod_t'(op[j]);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/qalu_combine.sv =====
`default_nettype none

module qalu_combine (
	input  wire qalu_pkg::stage_t st,
	input  wire qalu_pkg::row_t   row,
	output qalu_pkg::rsp_t        rsp
);

	qalu_pkg::fix36_t e [4][4];
	qalu_pkg::fix36_t xx, yy, zz, xy, xz, yz, wx, wy, wz;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				e[i][j] = qalu_pkg::ext32(st.p[i][j]);
			end
		end
	end

	// doubled matrix terms
	always_comb begin
		xx = e[1][1] <<< 1;
		yy = e[2][2] <<< 1;
		zz = e[3][3] <<< 1;
		xy = e[1][2] <<< 1;
		xz = e[1][3] <<< 1;
		yz = e[2][3] <<< 1;
		wx = e[0][1] <<< 1;
		wy = e[0][2] <<< 1;
		wz = e[0][3] <<< 1;
	end

	always_comb begin
		rsp.out_0 = '0;
		rsp.out_1 = '0;
		rsp.out_2 = '0;
		rsp.out_3 = '0;
		rsp.last = (st.action != qalu_pkg::ACT_MAT) || (row == qalu_pkg::ROW_LAST);
		unique case (st.action)
			qalu_pkg::ACT_ADD: begin
				rsp.out_0 = (qalu_pkg::ext16(st.a[0]) + qalu_pkg::ext16(st.b[0]))
					<<< qalu_pkg::Q14_SHIFT;
				rsp.out_1 = (qalu_pkg::ext16(st.a[1]) + qalu_pkg::ext16(st.b[1]))
					<<< qalu_pkg::Q14_SHIFT;
				rsp.out_2 = (qalu_pkg::ext16(st.a[2]) + qalu_pkg::ext16(st.b[2]))
					<<< qalu_pkg::Q14_SHIFT;
				rsp.out_3 = (qalu_pkg::ext16(st.a[3]) + qalu_pkg::ext16(st.b[3]))
					<<< qalu_pkg::Q14_SHIFT;
			end
			qalu_pkg::ACT_SUB: begin
				rsp.out_0 = (qalu_pkg::ext16(st.a[0]) - qalu_pkg::ext16(st.b[0]))
					<<< qalu_pkg::Q14_SHIFT;
				rsp.out_1 = (qalu_pkg::ext16(st.a[1]) - qalu_pkg::ext16(st.b[1]))
					<<< qalu_pkg::Q14_SHIFT;
				rsp.out_2 = (qalu_pkg::ext16(st.a[2]) - qalu_pkg::ext16(st.b[2]))
					<<< qalu_pkg::Q14_SHIFT;
				rsp.out_3 = (qalu_pkg::ext16(st.a[3]) - qalu_pkg::ext16(st.b[3]))
					<<< qalu_pkg::Q14_SHIFT;
			end
			qalu_pkg::ACT_MUL: begin
				rsp.out_0 = e[0][0] - e[1][1] - e[2][2] - e[3][3];
				rsp.out_1 = e[0][1] + e[1][0] + e[2][3] - e[3][2];
				rsp.out_2 = e[0][2] - e[1][3] + e[2][0] + e[3][1];
				rsp.out_3 = e[0][3] + e[1][2] - e[2][1] + e[3][0];
			end
			qalu_pkg::ACT_SCALE: begin
				rsp.out_0 = e[0][0];
				rsp.out_1 = e[1][0];
				rsp.out_2 = e[2][0];
				rsp.out_3 = e[3][0];
			end
			qalu_pkg::ACT_CONJ: begin
				rsp.out_0 = qalu_pkg::ext16(st.a[0]) <<< qalu_pkg::Q14_SHIFT;
				rsp.out_1 = (-qalu_pkg::ext16(st.a[1])) <<< qalu_pkg::Q14_SHIFT;
				rsp.out_2 = (-qalu_pkg::ext16(st.a[2])) <<< qalu_pkg::Q14_SHIFT;
				rsp.out_3 = (-qalu_pkg::ext16(st.a[3])) <<< qalu_pkg::Q14_SHIFT;
			end
			qalu_pkg::ACT_NEG: begin
				rsp.out_0 = (-qalu_pkg::ext16(st.a[0])) <<< qalu_pkg::Q14_SHIFT;
				rsp.out_1 = (-qalu_pkg::ext16(st.a[1])) <<< qalu_pkg::Q14_SHIFT;
				rsp.out_2 = (-qalu_pkg::ext16(st.a[2])) <<< qalu_pkg::Q14_SHIFT;
				rsp.out_3 = (-qalu_pkg::ext16(st.a[3])) <<< qalu_pkg::Q14_SHIFT;
			end
			qalu_pkg::ACT_DOT: begin
				rsp.out_0 = e[0][0] + e[1][1] + e[2][2] + e[3][3];
			end
			qalu_pkg::ACT_MAT: begin
				unique case (row)
					qalu_pkg::ROW_FIRST: begin
						rsp.out_0 = qalu_pkg::ONE_Q28 - yy - zz;
						rsp.out_1 = xy - wz;
						rsp.out_2 = xz + wy;
					end
					qalu_pkg::ROW_MID: begin
						rsp.out_0 = xy + wz;
						rsp.out_1 = qalu_pkg::ONE_Q28 - xx - zz;
						rsp.out_2 = yz - wx;
					end
					qalu_pkg::ROW_LAST: begin
						rsp.out_0 = xz - wy;
						rsp.out_1 = yz + wx;
						rsp.out_2 = qalu_pkg::ONE_Q28 - xx - yy;
					end
					default: begin
						rsp.out_0 = '0;
					end
				endcase
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== tb/tb_quaternion_alu.sv =====
`timescale 1ns / 1ps

module tb_quaternion_alu;

	localparam int N_RANDOM = 140;
	localparam qalu_pkg::fix16_t Q_MAX = 16'sh7fff;
	localparam qalu_pkg::fix16_t Q_MIN = 16'sh8000;
	localparam qalu_pkg::fix16_t Q_ONE = 16'sh4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	qalu_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	qalu_pkg::rsp_t rsp;

	qalu_pkg::req_t pending_reqs[$];
	qalu_pkg::rsp_t rsp_due[$];
	int n_total = 0;
	int n_accepted = 0;
	int n_mismatch = 0;
	int tx_idle;
	int rx_idle;

	quaternion_alu DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @* begin
		if (n_accepted < n_total / 3) begin
			tx_idle = 11;
			rx_idle = 82;
		end else if (n_accepted < (2 * n_total) / 3) begin
			tx_idle = 82;
			rx_idle = 11;
		end else begin
			tx_idle = 0;
			rx_idle = 0;
		end
	end

	function automatic qalu_pkg::fix16_t pick16();
		int sel;
		sel = $urandom_range(9);
		case (sel)
			0: return Q_MAX;
			1: return Q_MIN;
			2: return 16'sd0;
			3: return -16'sd1;
			4: return Q_ONE;
			5: return -Q_ONE;
			default: return qalu_pkg::fix16_t'($urandom);
		endcase
	endfunction

	function automatic qalu_pkg::req_t uniform_req(qalu_pkg::action_t act,
		qalu_pkg::fix16_t av, qalu_pkg::fix16_t bv, qalu_pkg::fix16_t sv);
		qalu_pkg::req_t r;
		r.action = act;
		r.a_w = av;
		r.a_x = av;
		r.a_y = av;
		r.a_z = av;
		r.b_w = bv;
		r.b_x = bv;
		r.b_y = bv;
		r.b_z = bv;
		r.scalar = sv;
		return r;
	endfunction

	function automatic void predict_quat(input qalu_pkg::req_t r);
		longint aw, ax, ay, az, bw, bx, by, bz, s, one14, one28;
		longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
		qalu_pkg::rsp_t e;
		aw = longint'($signed(r.a_w));
		ax = longint'($signed(r.a_x));
		ay = longint'($signed(r.a_y));
		az = longint'($signed(r.a_z));
		bw = longint'($signed(r.b_w));
		bx = longint'($signed(r.b_x));
		by = longint'($signed(r.b_y));
		bz = longint'($signed(r.b_z));
		s = longint'($signed(r.scalar));
		one14 = longint'(1) << qalu_pkg::Q14_SHIFT;
		one28 = longint'(qalu_pkg::ONE_Q28);
		e = '0;
		e.last = 1'b1;
		case (r.action)
			qalu_pkg::ACT_ADD: begin
				e.out_0 = qalu_pkg::fix36_t'((aw + bw) * one14);
				e.out_1 = qalu_pkg::fix36_t'((ax + bx) * one14);
				e.out_2 = qalu_pkg::fix36_t'((ay + by) * one14);
				e.out_3 = qalu_pkg::fix36_t'((az + bz) * one14);
			end
			qalu_pkg::ACT_SUB: begin
				e.out_0 = qalu_pkg::fix36_t'((aw - bw) * one14);
				e.out_1 = qalu_pkg::fix36_t'((ax - bx) * one14);
				e.out_2 = qalu_pkg::fix36_t'((ay - by) * one14);
				e.out_3 = qalu_pkg::fix36_t'((az - bz) * one14);
			end
			qalu_pkg::ACT_MUL: begin
				e.out_0 = qalu_pkg::fix36_t'(aw * bw - ax * bx - ay * by - az * bz);
				e.out_1 = qalu_pkg::fix36_t'(aw * bx + ax * bw + ay * bz - az * by);
				e.out_2 = qalu_pkg::fix36_t'(aw * by - ax * bz + ay * bw + az * bx);
				e.out_3 = qalu_pkg::fix36_t'(aw * bz + ax * by - ay * bx + az * bw);
			end
			qalu_pkg::ACT_SCALE: begin
				e.out_0 = qalu_pkg::fix36_t'(aw * s);
				e.out_1 = qalu_pkg::fix36_t'(ax * s);
				e.out_2 = qalu_pkg::fix36_t'(ay * s);
				e.out_3 = qalu_pkg::fix36_t'(az * s);
			end
			qalu_pkg::ACT_CONJ: begin
				e.out_0 = qalu_pkg::fix36_t'(aw * one14);
				e.out_1 = qalu_pkg::fix36_t'(-ax * one14);
				e.out_2 = qalu_pkg::fix36_t'(-ay * one14);
				e.out_3 = qalu_pkg::fix36_t'(-az * one14);
			end
			qalu_pkg::ACT_NEG: begin
				e.out_0 = qalu_pkg::fix36_t'(-aw * one14);
				e.out_1 = qalu_pkg::fix36_t'(-ax * one14);
				e.out_2 = qalu_pkg::fix36_t'(-ay * one14);
				e.out_3 = qalu_pkg::fix36_t'(-az * one14);
			end
			qalu_pkg::ACT_DOT: begin
				e.out_0 = qalu_pkg::fix36_t'(aw * bw + ax * bx + ay * by + az * bz);
			end
			default: begin
				xx = 2 * ax * ax;
				yy = 2 * ay * ay;
				zz = 2 * az * az;
				xy = 2 * ax * ay;
				xz = 2 * ax * az;
				yz = 2 * ay * az;
				wx = 2 * aw * ax;
				wy = 2 * aw * ay;
				wz = 2 * aw * az;
				e.last = 1'b0;
				e.out_0 = qalu_pkg::fix36_t'(one28 - yy - zz);
				e.out_1 = qalu_pkg::fix36_t'(xy - wz);
				e.out_2 = qalu_pkg::fix36_t'(xz + wy);
				rsp_due.push_back(e);
				e.out_0 = qalu_pkg::fix36_t'(xy + wz);
				e.out_1 = qalu_pkg::fix36_t'(one28 - xx - zz);
				e.out_2 = qalu_pkg::fix36_t'(yz - wx);
				rsp_due.push_back(e);
				e.out_0 = qalu_pkg::fix36_t'(xz - wy);
				e.out_1 = qalu_pkg::fix36_t'(yz + wx);
				e.out_2 = qalu_pkg::fix36_t'(one28 - xx - yy);
				e.last = 1'b1;
			end
		endcase
		rsp_due.push_back(e);
	endfunction

	function automatic logic signed [35:0] rsp_field(input qalu_pkg::rsp_t r, input int idx);
		case (idx)
			0: return r.out_0;
			1: return r.out_1;
			2: return r.out_2;
			3: return r.out_3;
			default: return {35'd0, r.last};
		endcase
	endfunction

	task automatic check_rsp(input qalu_pkg::rsp_t got);
		qalu_pkg::rsp_t want;
		if (rsp_due.size() == 0) begin
			n_mismatch++;
			if (n_mismatch <= 10)
				$display("unexpected response %h at %0t", got, $realtime);
			return;
		end
		want = rsp_due.pop_front();
		for (int i = 0; i < 5; i++) begin
			if (rsp_field(got, i) !== rsp_field(want, i)) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("field %0d at %0t: expected %0d, actual %0d", i, $realtime,
						rsp_field(want, i), rsp_field(got, i));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && req_ready) begin
				predict_quat(req);
				n_accepted <= n_accepted + 1;
			end
			if (!req_valid || req_ready) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle) begin
					req_valid <= 1'b1;
					req <= pending_reqs.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= rx_idle);
			if (rsp_valid && rsp_ready)
				check_rsp(rsp);
		end
	end

	initial begin
		qalu_pkg::req_t r;
		// extremes for every action
		for (int i = 0; i < 8; i++) begin
			pending_reqs.push_back(uniform_req(qalu_pkg::action_t'(i), Q_MAX, Q_MIN, Q_MIN));
			pending_reqs.push_back(uniform_req(qalu_pkg::action_t'(i), Q_MIN, Q_MIN, Q_MIN));
		end
		pending_reqs.push_back(uniform_req(qalu_pkg::ACT_ADD, Q_MAX, Q_MAX, 16'sd0));
		pending_reqs.push_back(uniform_req(qalu_pkg::ACT_SUB, Q_MIN, Q_MAX, 16'sd0));
		pending_reqs.push_back(uniform_req(qalu_pkg::ACT_SCALE, Q_MAX, 16'sd0, Q_ONE));
		pending_reqs.push_back(uniform_req(qalu_pkg::ACT_MUL, 16'sd0, 16'sd0, 16'sd0));
		// identity rotation
		r = '0;
		r.action = qalu_pkg::ACT_MAT;
		r.a_w = Q_ONE;
		pending_reqs.push_back(r);
		for (int i = 0; i < N_RANDOM; i++) begin
			r.action = qalu_pkg::action_t'($urandom_range(7));
			r.a_w = pick16();
			r.a_x = pick16();
			r.a_y = pick16();
			r.a_z = pick16();
			r.b_w = pick16();
			r.b_x = pick16();
			r.b_y = pick16();
			r.b_z = pick16();
			r.scalar = pick16();
			pending_reqs.push_back(r);
		end
		n_total = pending_reqs.size();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs.size() != 0 || req_valid)
			@(posedge clk);
		while (rsp_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (n_mismatch == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
